// ----- rtl/rsg_pkg.sv -----
// Package of the resist-switch guide filter: widths, window depth, codes,
// and the command and status types between controller and datapath.
// No dependencies.
package rsg_pkg;

  localparam int unsigned WINDOW_DEPTH = 10;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned THR_W        = 13;
  localparam int unsigned SIDE_W       = 2;
  localparam int unsigned CAUSE_W      = 3;
  localparam int unsigned IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1) + 1;
  localparam int unsigned SUM_W        = DATA_W + 2;
  localparam int unsigned SUM_TAPS     = 3;
  localparam int unsigned SWITCH_COUNT = 3;

  localparam logic [THR_W-1:0] MIN_MOVE_DEFAULT = THR_W'(51);

  // two's complement direction codes
  localparam logic [SIDE_W-1:0] SIDE_NONE = 2'b00;
  localparam logic [SIDE_W-1:0] SIDE_POS  = 2'b01;
  localparam logic [SIDE_W-1:0] SIDE_NEG  = 2'b11;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_PASS      = 3'd0,
    CAUSE_SMALL     = 3'd1,
    CAUSE_WEAK      = 3'd2,
    CAUSE_NOWORSE   = 3'd3,
    CAUSE_OVERSHOOT = 3'd4
  } cause_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic start;   // shift the sample in, clear the accumulators
    logic step;    // examine one window entry and rotate
    logic decide;  // load the result register
  } cmd_t;

  typedef struct packed {
    logic walk_last;
  } sts_t;

endpackage

// ----- rtl/rsg_chan_if.sv -----
// Valid/ready channel interfaces of the guide filter: sample input,
// result output and threshold write. Depends on rsg_pkg.
interface rsg_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsg_pkg::DATA_W-1:0]  error_sample;
  modport source (output valid, output error_sample, input ready);
  modport sink   (input valid, input error_sample, output ready);
endinterface

interface rsg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsg_pkg::DATA_W-1:0]  guide_value;
  logic                               accepted;
  logic signed [rsg_pkg::SIDE_W-1:0]  committed_side;
  logic [rsg_pkg::CAUSE_W-1:0]        veto_cause;
  modport source (output valid, output guide_value, output accepted,
                  output committed_side, output veto_cause, input ready);
  modport sink   (input valid, input guide_value, input accepted,
                  input committed_side, input veto_cause, output ready);
endinterface

interface rsg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rsg_pkg::THR_W-1:0]          data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rsg_ctrl.sv -----
// Controller of the guide filter: sequences accept, window walk and decision,
// and owns the output valid flag. Depends on rsg_pkg.
module rsg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsg_pkg::cmd_t cmd_o,
  input  rsg_pkg::sts_t sts_i
);
  import rsg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the previous result has been taken
        if (slot_free) begin
          cmd_o.decide = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/rsg_dpath.sv -----
// Datapath of the guide filter: sample window, threshold and direction
// registers, walk accumulators and the result register. Depends on rsg_pkg.
module rsg_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsg_pkg::cmd_t                     cmd_i,
  output rsg_pkg::sts_t                     sts_o,
  input  logic signed [rsg_pkg::DATA_W-1:0] sample_i,
  input  logic                              cfg_we_i,
  input  logic [rsg_pkg::THR_W-1:0]         cfg_data_i,
  output logic signed [rsg_pkg::DATA_W-1:0] guide_value_o,
  output logic                              accepted_o,
  output logic signed [rsg_pkg::SIDE_W-1:0] committed_side_o,
  output logic [rsg_pkg::CAUSE_W-1:0]       veto_cause_o
);
  import rsg_pkg::*;

  localparam logic [IDX_W-1:0]        IDX_LAST   = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [IDX_W-1:0]        IDX_NEWEST = IDX_W'(WINDOW_DEPTH - SUM_TAPS);
  localparam logic [IDX_W-1:0]        IDX_OLDEST = IDX_W'(SUM_TAPS);
  localparam logic signed [CNT_W-1:0] CNT_PLUS1  = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CNT_MINUS1 = -CNT_PLUS1;
  localparam logic signed [CNT_W-1:0] SW_POS     = CNT_W'(SWITCH_COUNT);
  localparam logic signed [CNT_W-1:0] SW_NEG     = -SW_POS;

  logic signed [DATA_W-1:0] win_q [WINDOW_DEPTH];
  logic [THR_W-1:0]         thr_q;
  logic [SIDE_W-1:0]        held_q, held_d;
  logic signed [DATA_W-1:0] sample_q;
  logic [IDX_W-1:0]         idx_q;
  logic signed [CNT_W-1:0]  cnt_q;
  logic signed [SUM_W-1:0]  old_q, new_q;

  logic signed [DATA_W-1:0] guide_q;
  logic                     acc_q;
  logic [SIDE_W-1:0]        side_q;
  cause_e                   cause_q, cause_d;

  // head tap of the rotating window
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W:0]   head_ext, x_ext;
  logic [DATA_W:0]          head_abs, x_abs;
  logic signed [SUM_W:0]    old_ext, new_ext;
  logic [SUM_W:0]           old_abs, new_abs;
  logic [SIDE_W-1:0]        cnt_sgn, cnt_neg, x_sgn;
  logic                     consider;

  assign head     = win_q[0];
  assign head_ext = (DATA_W + 1)'(head);
  assign head_abs = head[DATA_W-1] ? $unsigned(-head_ext) : $unsigned(head_ext);
  assign x_ext    = (DATA_W + 1)'(sample_q);
  assign x_abs    = sample_q[DATA_W-1] ? $unsigned(-x_ext) : $unsigned(x_ext);
  assign old_ext  = (SUM_W + 1)'(old_q);
  assign new_ext  = (SUM_W + 1)'(new_q);
  assign old_abs  = old_q[SUM_W-1] ? $unsigned(-old_ext) : $unsigned(old_ext);
  assign new_abs  = new_q[SUM_W-1] ? $unsigned(-new_ext) : $unsigned(new_ext);

  assign sts_o.walk_last = (idx_q == IDX_LAST);

  // window, walk accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.start) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_DEPTH-1] <= sample_i;
    end else if (cmd_i.step) begin
      // rotate; after a full walk the order is restored
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_DEPTH-1] <= head;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sample_q <= sample_i;
      idx_q    <= '0;
      cnt_q    <= '0;
      old_q    <= '0;
      new_q    <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
      if (head_abs > (DATA_W + 1)'(thr_q)) begin
        cnt_q <= cnt_q + (head[DATA_W-1] ? CNT_MINUS1 : CNT_PLUS1);
      end
      if (idx_q < IDX_OLDEST) begin
        old_q <= old_q + SUM_W'(head);
      end
      if (idx_q >= IDX_NEWEST) begin
        new_q <= new_q + SUM_W'(head);
      end
    end
  end

  // decision
  always_comb begin
    cnt_sgn = (cnt_q == '0) ? SIDE_NONE : (cnt_q[CNT_W-1] ? SIDE_NEG : SIDE_POS);
    cnt_neg = (cnt_q == '0) ? SIDE_NONE : (cnt_q[CNT_W-1] ? SIDE_POS : SIDE_NEG);
    x_sgn   = (sample_q == '0) ? SIDE_NONE :
              (sample_q[DATA_W-1] ? SIDE_NEG : SIDE_POS);
    consider = (held_q == SIDE_NONE) || (held_q == cnt_neg);
    held_d  = held_q;
    cause_d = CAUSE_PASS;
    if (x_abs < (DATA_W + 1)'(thr_q)) begin
      cause_d = CAUSE_SMALL;
    end else begin
      if (consider) begin
        if (cnt_q < SW_POS && cnt_q > SW_NEG) begin
          cause_d = CAUSE_WEAK;
        end else if (new_abs <= old_abs) begin
          cause_d = CAUSE_NOWORSE;
        end else begin
          held_d = cnt_sgn;
        end
      end
      // a successful switch is kept even when the sample overshoots
      if (cause_d == CAUSE_PASS && held_d != x_sgn) begin
        cause_d = CAUSE_OVERSHOOT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= MIN_MOVE_DEFAULT;
      held_q <= SIDE_NONE;
    end else if (cfg_we_i) begin
      thr_q  <= (cfg_data_i == '0) ? MIN_MOVE_DEFAULT : cfg_data_i;
      held_q <= SIDE_NONE;
    end else if (cmd_i.decide) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      guide_q <= (cause_d == CAUSE_PASS) ? sample_q : '0;
      acc_q   <= (cause_d == CAUSE_PASS);
      side_q  <= held_d;
      cause_q <= cause_d;
    end
  end

  assign guide_value_o    = guide_q;
  assign accepted_o       = acc_q;
  assign committed_side_o = $signed(side_q);
  assign veto_cause_o     = cause_q;

endmodule

// ----- rtl/resist_switch_guide_filter_unit.sv -----
// Top level of the resist-switch guide filter: joins controller, datapath
// and the channel interfaces. Depends on rsg_pkg, rsg_chan_if, rsg_ctrl, rsg_dpath.
//
//   channel  dir  payload                                            handshake
//   in_i     in   error_sample                                       valid/ready
//   out_o    out  guide_value, accepted, committed_side, veto_cause  valid/ready
//   cfg_i    in   data (min_move_threshold)                          valid/ready
//
// Each item passes an accept state, a walk in which every window entry rotates
// past the single compare/add tap in turn, and a decision state. The result sits
// in an output register; the next item is taken while it waits, and only the
// decision state stalls on out_o.ready.
// Reset zeroes the window, clears the held direction and loads threshold 51.
// cfg_i is always ready; a write also clears the held direction.
module resist_switch_guide_filter_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsg_in_if.sink    in_i,
  rsg_out_if.source out_o,
  rsg_cfg_if.sink   cfg_i
);
  import rsg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  rsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rsg_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (in_i.error_sample),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .guide_value_o    (out_o.guide_value),
    .accepted_o       (out_o.accepted),
    .committed_side_o (out_o.committed_side),
    .veto_cause_o     (out_o.veto_cause)
  );

endmodule

// ----- tb/testbench.sv -----
// Testbench of resist_switch_guide_filter_unit: random and directed error samples
// are checked against a cycle-free predictor of the window/direction logic.
// Depends on rsg_pkg, the rsg_*_if channel interfaces and the filter RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsg_pkg::*;

  localparam int ITEM_CYCLES = WINDOW_DEPTH + 2;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RUN_PHASES  = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int S_MAX       = (1 << (DATA_W - 1)) - 1;
  localparam int S_MIN       = -S_MAX - 1;

  typedef struct {
    logic signed [DATA_W-1:0] guide;
    logic                     acc;
    logic signed [SIDE_W-1:0] side;
    cause_e                   cause;
  } guide_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsg_in_if  in_ch ();
  rsg_out_if out_ch ();
  rsg_cfg_if cfg_ch ();

  resist_switch_guide_filter_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // predictor state
  int win_hist [WINDOW_DEPTH];
  int held_dir;
  int thr_now;

  guide_result_t            expected_guides [$];
  logic signed [DATA_W-1:0] samples_to_send [$];

  int   errors       = 0;
  int   idle_pct     = 0;
  int   hold_reqs    = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   quiet_cycles = 0;
  logic in_taken     = 1'b0;

  always #5ns clk_i = ~clk_i;

  function automatic int sign_of(input int v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int abs_of(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp16(input int v);
    if (v > S_MAX) return DATA_W'(S_MAX);
    if (v < S_MIN) return DATA_W'(S_MIN);
    return DATA_W'(v);
  endfunction

  // Shifts the sample into the window and decides pass/veto and direction.
  function automatic guide_result_t predict_guide(input logic signed [DATA_W-1:0] x);
    guide_result_t r;
    int            xv;
    int            cnt;
    int            old_sum;
    int            new_sum;
    int            i;
    cause_e        why;
    xv      = x;
    cnt     = 0;
    old_sum = 0;
    new_sum = 0;
    why     = CAUSE_PASS;
    for (i = 0; i < int'(WINDOW_DEPTH) - 1; i++) win_hist[i] = win_hist[i+1];
    win_hist[WINDOW_DEPTH-1] = xv;
    if (abs_of(xv) < thr_now) begin
      why = CAUSE_SMALL;
    end else begin
      for (i = 0; i < int'(WINDOW_DEPTH); i++)
        if (abs_of(win_hist[i]) > thr_now) cnt += sign_of(win_hist[i]);
      // a zero count never opposes a held direction
      if (held_dir == 0 || held_dir == -sign_of(cnt)) begin
        if (abs_of(cnt) < int'(SWITCH_COUNT)) begin
          why = CAUSE_WEAK;
        end else begin
          for (i = 0; i < int'(SUM_TAPS); i++) begin
            old_sum += win_hist[i];
            new_sum += win_hist[int'(WINDOW_DEPTH) - 1 - i];
          end
          if (abs_of(new_sum) <= abs_of(old_sum)) why = CAUSE_NOWORSE;
          else held_dir = sign_of(cnt);
        end
      end
      // the switch sticks even when this sample is then vetoed
      if (why == CAUSE_PASS && held_dir != sign_of(xv)) why = CAUSE_OVERSHOOT;
    end
    r.guide = (why == CAUSE_PASS) ? x : '0;
    r.acc   = (why == CAUSE_PASS);
    r.side  = SIDE_W'(held_dir);
    r.cause = why;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Runs of same-signed moves that grow or decay, with small, opposite,
  // extreme and full-range samples mixed in.
  task automatic queue_random_runs(input int n_items, input int t);
    int left;
    int len;
    int dir;
    int mag;
    int step;
    int kind;
    int v;
    int k;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(3, 12);
      dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
      mag = t + int'($urandom_range(1, 2 * t + 64));
      if ($urandom_range(0, 2) == 0) step = -(t / 4 + 1);
      else step = int'($urandom_range(0, t / 2 + 8));
      for (k = 0; k < len && left > 0; k++) begin
        kind = $urandom_range(0, 19);
        case (kind)
          0:       v = int'($urandom_range(0, 65535)) - 32768;
          1:       v = dir * int'($urandom_range(0, t - 1));
          2:       v = -dir * (t + int'($urandom_range(0, t)));
          3:       v = (dir > 0) ? S_MAX : S_MIN;
          4:       v = dir * t;
          5:       v = dir * (t + 1);
          default: v = dir * mag;
        endcase
        mag += step;
        if (mag <= t) mag = t + 1;
        samples_to_send.push_back(clamp16(v));
        left--;
      end
    end
  endtask

  task automatic write_threshold(input int v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= THR_W'(v);
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_until_settled();
    do @(posedge clk_i);
    while (samples_to_send.size() != 0 || in_ch.valid || expected_guides.size() != 0);
  endtask

  // sample driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // request still pending, hold it
    end else if (send_gap > 0) begin
      send_gap--;
      in_ch.valid <= 1'b0;
    end else if (samples_to_send.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
      send_gap = $urandom_range(1, 12) - 1;
      in_ch.valid <= 1'b0;
    end else if (samples_to_send.size() > 0) begin
      in_ch.valid        <= 1'b1;
      in_ch.error_sample <= samples_to_send.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      recv_gap = $urandom_range(1, 12) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    guide_result_t want;
    if (rst_ni) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        thr_now  = (cfg_ch.data == '0) ? int'(MIN_MOVE_DEFAULT) : int'(cfg_ch.data);
        held_dir = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_guides.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected none, actual guide_value %0d",
                   $time, out_ch.guide_value);
        end else begin
          want = expected_guides.pop_front();
          check_field("guide_value", want.guide, out_ch.guide_value);
          check_field("accepted", want.acc, out_ch.accepted);
          check_field("committed_side", want.side, out_ch.committed_side);
          check_field("veto_cause", want.cause, out_ch.veto_cause);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_guides.push_back(predict_guide(in_ch.error_sample));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int i;
    int t;
    int phase_thr  [RUN_PHASES];
    int phase_idle [RUN_PHASES];
    int first_seq [15];
    int wide_seq  [4];
    int fine_seq  [4];

    // from reset: small, weak, switch, overshoot, zero count, not worsening, switch back
    first_seq = '{0, -51, 51, 52, 52, 52, -32768, 32767,
                  -52, -52, -52, -52, -52, -52, -52};
    wide_seq  = '{-32768, 8191, 8190, 32767};
    fine_seq  = '{1, 0, -1, 2};

    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.error_sample  = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    for (i = 0; i < int'(WINDOW_DEPTH); i++) win_hist[i] = 0;
    held_dir = 0;
    thr_now  = int'(MIN_MOVE_DEFAULT);

    phase_thr[0] = 5120;
    phase_thr[1] = $urandom_range(1, 300);
    phase_thr[2] = 51;
    phase_thr[3] = 1;
    phase_thr[4] = 8191;
    phase_thr[5] = $urandom_range(1, 5120);
    phase_thr[6] = 0;
    phase_thr[7] = $urandom_range(1, 64);
    phase_thr[8] = $urandom_range(1, 1000);
    phase_thr[9] = $urandom_range(1, 5120);
    phase_idle = '{10, 0, 25, 5, 40, 0, 15, 30, 0, 0};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 20;
    foreach (first_seq[i]) samples_to_send.push_back(clamp16(first_seq[i]));
    wait_until_settled();

    // zero write falls back to the default and clears the side; then a
    // switch that lands on an opposite-signed sample
    write_threshold(0);
    samples_to_send.push_back(clamp16(200));
    wait_until_settled();

    write_threshold(8191);
    foreach (wide_seq[i]) samples_to_send.push_back(clamp16(wide_seq[i]));
    wait_until_settled();

    write_threshold(1);
    foreach (fine_seq[i]) samples_to_send.push_back(clamp16(fine_seq[i]));
    wait_until_settled();

    for (p = 0; p < RUN_PHASES; p++) begin
      write_threshold(phase_thr[p]);
      idle_pct = phase_idle[p];
      // long receiver stall so the block backs up into its input
      if (p == 2) hold_reqs++;
      t = (phase_thr[p] % (1 << THR_W) == 0) ? int'(MIN_MOVE_DEFAULT)
                                            : phase_thr[p] % (1 << THR_W);
      queue_random_runs(PHASE_ITEMS, t);
      wait_until_settled();
    end

    repeat (2 * ITEM_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_guides.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
